>>> rtl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Operation codes, result status codes, back-end states and the command
// word that travels from the front end through the command queue.
// ---------------------------------------------------------------------------
package dq_pkg;

   // Operation codes as seen on req_operation
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST       = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Value width of one entry
   localparam int unsigned VALUE_W = 32;

   // Command queue between front and back end
   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned CMDQ_PTR_W = 1;
   localparam int unsigned CMDQ_CNT_W = 2;

   // One accepted command word
   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LIST
   } state_type;

endpackage

>>> rtl/dq_front.sv
// ---------------------------------------------------------------------------
// dq_front: request front end
// Takes a word when start is high and the command queue has room, drops
// unused operation codes and forwards valid commands to the queue.
// ---------------------------------------------------------------------------
module dq_front (
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_item_value,
   input  logic               cmdq_full,
   output logic               cmdq_push,
   output dq_pkg::cmd_type    cmdq_cmd
);

   logic accept;
   logic known_op;

   assign busy   = cmdq_full;
   assign accept = start & ~cmdq_full;

   // Classify the operation code; codes 6 and 7 cause nothing
   always_comb begin
      unique case (dq_pkg::op_type'(req_operation)) inside
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_POP_FRONT, dq_pkg::OP_PUSH_BACK,
         dq_pkg::OP_POP_BACK, dq_pkg::OP_LIST, dq_pkg::OP_CLEAR: begin
            known_op = 1'b1;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   assign cmdq_push      = accept & known_op;
   assign cmdq_cmd.op    = dq_pkg::op_type'(req_operation);
   assign cmdq_cmd.value = req_item_value;

endmodule

>>> rtl/dq_cmdq.sv
// ---------------------------------------------------------------------------
// dq_cmdq: command queue
// Small register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module dq_cmdq (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dq_pkg::cmd_type push_cmd,
   output logic            full,
   input  logic            pop,
   output logic            cmd_valid,
   output dq_pkg::cmd_type cmd
);

   dq_pkg::cmd_type                   slot_ff [dq_pkg::CMDQ_DEPTH];
   logic [dq_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dq_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dq_pkg::CMDQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              do_push;
   logic                              do_pop;

   assign full      = (cnt_ff == dq_pkg::CMDQ_CNT_W'(dq_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & cmd_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Command words, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/dq_exec.sv
// ---------------------------------------------------------------------------
// dq_exec: back end
// Owns the circular entry store, the front index and the entry count, and
// carries out one command at a time, driving the result ports.
// ---------------------------------------------------------------------------
module dq_exec #(
   parameter int unsigned DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  dq_pkg::cmd_type    cmd,
   output logic               cmd_pop,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   dq_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          list_ff, list_in;
   logic [IDX_W-1:0]          list_addr_ff, list_addr_in;
   logic                      res_valid_ff, res_valid_in;
   logic [1:0]                res_status_ff, res_status_in;

   logic [dq_pkg::VALUE_W-1:0] entry_store_ff [DEPTH];
   logic [dq_pkg::VALUE_W-1:0] rd_data_ff;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;

   logic                      is_empty;
   logic                      is_full;
   logic [IDX_W-1:0]          front_dec;
   logic [IDX_W-1:0]          front_inc;
   logic [IDX_W-1:0]          list_addr_inc;
   logic [SUM_W-1:0]          tail_sum;
   logic [SUM_W-1:0]          last_sum;
   logic [IDX_W-1:0]          tail_slot;
   logic [IDX_W-1:0]          last_slot;
   logic                      list_last;
   logic                      take_cmd;

   // Index arithmetic, all modulo DEPTH
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign list_addr_inc = (list_addr_ff == IDX_W'(DEPTH - 1)) ? '0
                                                              : list_addr_ff + 1'b1;
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign last_sum  = tail_sum - SUM_W'(1);
   assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
   assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(last_sum);
   assign list_last = ((CNT_W'(list_ff) + CNT_W'(1)) == count_ff);
   assign take_cmd  = (state_ff == dq_pkg::S_IDLE) & cmd_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
                     if (!is_empty) state_in = dq_pkg::S_POP;
                  end
                  dq_pkg::OP_LIST: begin
                     if (!is_empty) state_in = dq_pkg::S_LIST;
                  end
                  default: begin
                     state_in = dq_pkg::S_IDLE;
                  end
               endcase
            end
         end
         dq_pkg::S_POP: begin
            state_in = dq_pkg::S_IDLE;
         end
         dq_pkg::S_LIST: begin
            if (list_last) state_in = dq_pkg::S_IDLE;
         end
         default: begin
            state_in = dq_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath and store control
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      list_in       = list_ff;
      list_addr_in  = list_addr_ff;
      res_valid_in  = 1'b0;
      res_status_in = dq_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      cmd_pop       = take_cmd;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  dq_pkg::OP_PUSH_FRONT: begin
                     res_valid_in = 1'b1;
                     if (is_full) begin
                        res_status_in = dq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::OP_PUSH_BACK: begin
                     res_valid_in = 1'b1;
                     if (is_full) begin
                        res_status_in = dq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_slot;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     if (is_empty) begin
                        res_valid_in  = 1'b1;
                        res_status_in = dq_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dq_pkg::OP_POP_BACK: begin
                     if (is_empty) begin
                        res_valid_in  = 1'b1;
                        res_status_in = dq_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_slot;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dq_pkg::OP_LIST: begin
                     if (is_empty) begin
                        res_valid_in  = 1'b1;
                        res_status_in = dq_pkg::ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = front_ff;
                        list_in      = '0;
                        list_addr_in = front_inc;
                     end
                  end
                  dq_pkg::OP_CLEAR: begin
                     res_valid_in = 1'b1;
                     front_in     = '0;
                     count_in     = '0;
                  end
                  default: begin
                     res_valid_in = 1'b0;
                  end
               endcase
            end
         end
         dq_pkg::S_LIST: begin
            // Prefetch the next entry while the current one is reported
            rd_en        = 1'b1;
            rd_addr      = list_addr_ff;
            list_addr_in = list_addr_inc;
            list_in      = list_ff + 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Result outputs
   always_comb begin
      unique case (state_ff)
         dq_pkg::S_POP: begin
            rsp_strobe      = 1'b1;
            rsp_out_value   = rd_data_ff;
            rsp_status      = dq_pkg::ST_OK;
            rsp_last_of_run = 1'b1;
         end
         dq_pkg::S_LIST: begin
            rsp_strobe      = 1'b1;
            rsp_out_value   = rd_data_ff;
            rsp_status      = dq_pkg::ST_OK;
            rsp_last_of_run = list_last;
         end
         default: begin
            rsp_strobe      = res_valid_ff;
            rsp_out_value   = '0;
            rsp_status      = res_status_ff;
            rsp_last_of_run = 1'b1;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         list_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         list_ff      <= list_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      list_addr_ff  <= list_addr_in;
      res_status_ff <= res_status_in;
   end

   // Entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

endmodule

>>> rtl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Front end, command queue and back end around a circular entry store.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy only rises when
// the two-entry command queue is full. Results appear for exactly one cycle
// with rsp_strobe and must be captured then. In the back end a push, a clear
// or any empty/full report is registered and then strobed, a pop reads the
// store and then reports, and a list reads and reports the stored entries in
// turn, since the store has a single registered read port. Operation codes 6
// and 7 are taken and give no result.
module double_ended_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);

   logic            cmdq_full;
   logic            cmdq_push;
   dq_pkg::cmd_type cmdq_in;
   logic            cmdq_pop;
   logic            cmdq_valid;
   dq_pkg::cmd_type cmdq_out;

   dq_front u_front (
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_item_value (req_item_value),
      .cmdq_full      (cmdq_full),
      .cmdq_push      (cmdq_push),
      .cmdq_cmd       (cmdq_in)
   );

   dq_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_cmd  (cmdq_in),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .cmd_valid (cmdq_valid),
      .cmd       (cmdq_out)
   );

   dq_exec #(
      .DEPTH (DEPTH)
   ) u_exec (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmdq_valid),
      .cmd             (cmdq_out),
      .cmd_pop         (cmdq_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the double-ended queue
// Words go in on the start/busy command port and a shadow deque predicts
// every result word as each command word is taken. A checker compares each
// strobed result field by field with the oldest prediction. Directed tests
// cover the empty, full and unused-code cases, then random traffic runs in
// fill, drain and mixed modes with varying sender gaps.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QDEPTH      = 16;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned TAIL_CYCLES = 40;

   // Codes the block takes and ignores
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // Random traffic modes
   localparam int unsigned MODE_FILL  = 0;
   localparam int unsigned MODE_DRAIN = 1;
   localparam int unsigned MODE_MIXED = 2;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_operation;
   logic signed [31:0] req_item_value;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_value;
   logic [1:0]         rsp_status;
   logic               rsp_last_of_run;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               last;
   } result_word_type;

   // Predicted result words, oldest first
   result_word_type    pending_results[$];

   // Shadow deque
   logic signed [31:0] shadow_store[QDEPTH];
   int unsigned        shadow_front = 0;
   int unsigned        shadow_count = 0;

   int unsigned        error_count = 0;
   int unsigned        cycle_count = 0;

   double_ended_queue #(
      .DEPTH(QDEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_item_value (req_item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void expect_word(input logic signed [31:0] value,
                                       input logic [1:0] status, input logic last);
      result_word_type w;
      w.value  = value;
      w.status = status;
      w.last   = last;
      pending_results.push_back(w);
   endfunction

   // Shadow deque: apply one taken command word, queue its result words
   function automatic void predict_deque(input logic [2:0] op,
                                         input logic signed [31:0] value);
      int unsigned k;
      case (op)
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
            if (shadow_count >= QDEPTH) begin
               expect_word(0, dq_pkg::ST_FULL, 1'b1);
            end else begin
               if (op == dq_pkg::OP_PUSH_FRONT) begin
                  shadow_front = (shadow_front + QDEPTH - 1) % QDEPTH;
                  shadow_store[shadow_front] = value;
               end else begin
                  shadow_store[(shadow_front + shadow_count) % QDEPTH] = value;
               end
               shadow_count++;
               expect_word(0, dq_pkg::ST_OK, 1'b1);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (shadow_count == 0) begin
               expect_word(0, dq_pkg::ST_EMPTY, 1'b1);
            end else begin
               expect_word(shadow_store[shadow_front], dq_pkg::ST_OK, 1'b1);
               shadow_front = (shadow_front + 1) % QDEPTH;
               shadow_count--;
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (shadow_count == 0) begin
               expect_word(0, dq_pkg::ST_EMPTY, 1'b1);
            end else begin
               shadow_count--;
               expect_word(shadow_store[(shadow_front + shadow_count) % QDEPTH],
                           dq_pkg::ST_OK, 1'b1);
            end
         end
         dq_pkg::OP_LIST: begin
            if (shadow_count == 0) begin
               expect_word(0, dq_pkg::ST_EMPTY, 1'b1);
            end else begin
               for (k = 0; k < shadow_count; k++)
                  expect_word(shadow_store[(shadow_front + k) % QDEPTH], dq_pkg::ST_OK,
                              (k + 1 == shadow_count));
            end
         end
         dq_pkg::OP_CLEAR: begin
            shadow_count = 0;
            shadow_front = 0;
            expect_word(0, dq_pkg::ST_OK, 1'b1);
         end
         default: begin
            // unused codes: no result, no state change
         end
      endcase
   endfunction

   // Result checker
   always @(posedge clock) begin : check_results
      result_word_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %0d status %0d last %0b",
                                      rsp_out_value, rsp_status, rsp_last_of_run));
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_value !== want.value)
               report_mismatch($sformatf("out_value %0d, want %0d",
                                         rsp_out_value, want.value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_last_of_run !== want.last)
               report_mismatch($sformatf("last_of_run %0b, want %0b",
                                         rsp_last_of_run, want.last));
         end
      end
   end

   // Drive one command word and hold it until taken
   task automatic send_word(input logic [2:0] op, input logic signed [31:0] value);
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= op;
      req_item_value <= value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_deque(op, value);
   endtask

   // Sender gap with junk on the payload ports
   task automatic idle_sender(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start          <= 1'b0;
         req_operation  <= 3'($urandom);
         req_item_value <= $urandom;
      end
   endtask

   // Pops and list on an empty queue
   task automatic test_empty_queue();
      send_word(dq_pkg::OP_POP_FRONT, 32'sh7fffffff);
      send_word(dq_pkg::OP_POP_BACK, 32'sh80000000);
      send_word(dq_pkg::OP_LIST, -32'sd1);
   endtask

   // Push and pop at both ends with extreme values
   task automatic test_push_pop_ends();
      send_word(dq_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
      send_word(dq_pkg::OP_PUSH_BACK, 32'sh80000000);
      send_word(dq_pkg::OP_PUSH_FRONT, 32'sd0);
      send_word(dq_pkg::OP_PUSH_BACK, -32'sd1);
      send_word(dq_pkg::OP_LIST, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_CLEAR, 32'sh5a5a5a5a);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
   endtask

   // Fill to capacity, push on full at both ends, list all, pop at both ends, then clear
   task automatic test_full_queue();
      int unsigned k;
      for (k = 0; k < QDEPTH; k++)
         send_word(k[0] ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT, $urandom);
      send_word(dq_pkg::OP_PUSH_FRONT, 32'sh12345678);
      send_word(dq_pkg::OP_PUSH_BACK, 32'sh12345678);
      send_word(dq_pkg::OP_LIST, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_CLEAR, 32'sd0);
   endtask

   // Codes 6 and 7 are taken and give nothing
   task automatic test_unused_codes();
      send_word(OP_UNUSED_LO, 32'sh7fffffff);
      send_word(OP_UNUSED_HI, 32'sh80000000);
   endtask

   // Random traffic; modes bias toward filling, draining or a mix
   task automatic test_random_traffic(input int unsigned n_words,
                                      input int unsigned idle_pct);
      int unsigned        mode;
      int unsigned        roll;
      int unsigned        sent;
      logic [2:0]         op;
      logic signed [31:0] value;
      mode = MODE_FILL;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(31) == 0) mode = $urandom_range(MODE_MIXED);
         roll = $urandom_range(99);
         case (mode)
            MODE_FILL: begin
               if (roll < 72)
                  op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
               else if (roll < 86)
                  op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
               else
                  op = dq_pkg::OP_LIST;
            end
            MODE_DRAIN: begin
               if (roll < 72)
                  op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
               else if (roll < 86)
                  op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
               else
                  op = dq_pkg::OP_LIST;
            end
            default: begin
               if (roll < 30)
                  op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
               else if (roll < 60)
                  op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
               else if (roll < 80)
                  op = dq_pkg::OP_LIST;
               else if (roll < 88)
                  op = dq_pkg::OP_CLEAR;
               else
                  op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
            end
         endcase
         // bias some values to the extremes
         case ($urandom_range(7))
            0:       value = 32'sh7fffffff;
            1:       value = 32'sh80000000;
            2:       value = 32'sd0;
            3:       value = -32'sd1;
            default: value = $urandom;
         endcase
         send_word(op, value);
         if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) sent++;
         // each following cycle is idle with the given odds
         while ($urandom_range(99) < idle_pct) idle_sender(1);
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = dq_pkg::OP_PUSH_FRONT;
      req_item_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_push_pop_ends();
      test_full_queue();
      test_unused_codes();
      test_random_traffic(70, 0);
      test_random_traffic(70, 47);
      test_random_traffic(70, 25);

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
